>>> rtl/core/snfos_pkg.sv
// shared types and constants for the spi nor flash operation sequencer
`timescale 1ns / 1ps
package snfos_pkg;

   // field widths
   localparam int ACTION_W = 3;
   localparam int ADDR_W   = 24;
   localparam int LEN_W    = 21;
   localparam int STATUS_W = 8;
   localparam int DIR_W    = 3;
   localparam int OPC_W    = 8;
   localparam int TICKS_W  = 24;
   localparam int RES_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W = 2;

   // flash geometry
   localparam int MAX_ADDRESS = 1048575;
   localparam int PAGE_BYTES  = 256;
   localparam int PAGE_BITS   = $clog2(PAGE_BYTES);

   localparam logic [LEN_W-1:0] SZ_4K  = LEN_W'(4096);
   localparam logic [LEN_W-1:0] SZ_32K = LEN_W'(32768);
   localparam logic [LEN_W-1:0] SZ_64K = LEN_W'(65536);
   localparam logic [LEN_W-1:0] SZ_1M  = LEN_W'(1048576);

   // input actions
   localparam logic [ACTION_W-1:0] ACT_READ    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PROGRAM = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ERASE   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SLEEP   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DONE    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_TIMER   = 3'd5;

   // result directives
   localparam logic [DIR_W-1:0] DIR_ACCEPTED = 3'd0;
   localparam logic [DIR_W-1:0] DIR_SEND_CMD = 3'd1;
   localparam logic [DIR_W-1:0] DIR_SEND     = 3'd2;
   localparam logic [DIR_W-1:0] DIR_RECEIVE  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_RDSR     = 3'd4;
   localparam logic [DIR_W-1:0] DIR_RELEASE  = 3'd5;
   localparam logic [DIR_W-1:0] DIR_TIMER    = 3'd6;
   localparam logic [DIR_W-1:0] DIR_COMPLETE = 3'd7;

   // completion status
   localparam logic [RES_W-1:0] ST_OK        = 3'd0;
   localparam logic [RES_W-1:0] ST_BUSY      = 3'd1;
   localparam logic [RES_W-1:0] ST_BAD_RANGE = 3'd2;
   localparam logic [RES_W-1:0] ST_BAD_PARAM = 3'd3;
   localparam logic [RES_W-1:0] ST_BAD_COUNT = 3'd4;
   localparam logic [RES_W-1:0] ST_BAD_STATE = 3'd5;
   localparam logic [RES_W-1:0] ST_TX_ERROR  = 3'd6;

   // flash opcodes
   localparam logic [OPC_W-1:0] OPC_READ  = 8'h03;
   localparam logic [OPC_W-1:0] OPC_WREN  = 8'h06;
   localparam logic [OPC_W-1:0] OPC_RDSR  = 8'h05;
   localparam logic [OPC_W-1:0] OPC_PP    = 8'h02;
   localparam logic [OPC_W-1:0] OPC_SE4K  = 8'h20;
   localparam logic [OPC_W-1:0] OPC_BE32K = 8'h52;
   localparam logic [OPC_W-1:0] OPC_BE64K = 8'hd8;
   localparam logic [OPC_W-1:0] OPC_CE    = 8'h60;
   localparam logic [OPC_W-1:0] OPC_DP    = 8'hb9;

   // status register bits
   localparam int WIP_BIT = 0;
   localparam int WEL_BIT = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WEL_POLL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROG_TPB   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE_4K   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE_32K  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE_64K  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CHIP_ERASE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKEUP     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP      = 3'd7;

   typedef enum logic [4:0] {
      OP_NONE  = 5'b00001,
      OP_READ  = 5'b00010,
      OP_PROG  = 5'b00100,
      OP_ERASE = 5'b01000,
      OP_SLEEP = 5'b10000
   } op_type;

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_WAKE   = 8'b0000_0010,
      PH_WREN   = 8'b0000_0100,
      PH_CMD    = 8'b0000_1000,
      PH_DATA   = 8'b0001_0000,
      PH_PWAIT  = 8'b0010_0000,
      PH_PXFER  = 8'b0100_0000,
      PH_SETTLE = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      PT_NONE = 3'b001,
      PT_WEL  = 3'b010,
      PT_WIP  = 3'b100
   } poll_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
      logic                transfer_ok;
      logic [STATUS_W-1:0] status_byte;
   } req_type;

   typedef struct packed {
      logic [DIR_W-1:0]   directive;
      logic [OPC_W-1:0]   opcode;
      logic [ADDR_W-1:0]  cmd_address;
      logic               with_address;
      logic [LEN_W-1:0]   byte_count;
      logic [TICKS_W-1:0] timer_ticks;
      logic [RES_W-1:0]   status;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] wel_poll_ticks;
      logic [7:0]  program_ticks_per_byte;
      logic [23:0] erase_4k_ticks;
      logic [23:0] erase_32k_ticks;
      logic [23:0] erase_64k_ticks;
      logic [23:0] chip_erase_ticks;
      logic [7:0]  wakeup_ticks;
      logic [7:0]  sleep_settle_ticks;
   } cfg_type;

   typedef struct packed {
      op_type             op;
      phase_type          phase;
      poll_type           poll_target;
      logic               asleep;
      logic [ADDR_W-1:0]  op_address;
      logic [LEN_W-1:0]   op_length;
      logic [TICKS_W-1:0] poll_interval;
   } seq_state_type;

   // results caused by one item, sent in order from item[0]
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] item;
      logic [CNT_W-1:0]          count;
   } burst_type;

endpackage

>>> rtl/core/snfos_step.sv
// next-state and result logic for one input item
`timescale 1ns / 1ps
module snfos_step (
   input  snfos_pkg::seq_state_type st,
   input  snfos_pkg::cfg_type       cfg,
   input  snfos_pkg::req_type       req,
   output snfos_pkg::seq_state_type nx,
   output snfos_pkg::burst_type     burst
);
   import snfos_pkg::*;

   function automatic rsp_type mk_rsp(
      input logic [DIR_W-1:0]   dir,
      input logic [OPC_W-1:0]   opc,
      input logic [ADDR_W-1:0]  addr,
      input logic               wa,
      input logic [LEN_W-1:0]   cnt,
      input logic [TICKS_W-1:0] ticks,
      input logic [RES_W-1:0]   sts
   );
      rsp_type r;
      r.directive    = dir;
      r.opcode       = opc;
      r.cmd_address  = addr;
      r.with_address = wa;
      r.byte_count   = cnt;
      r.timer_ticks  = ticks;
      r.status       = sts;
      r.last         = 1'b0;
      return r;
   endfunction

   logic [CNT_W-1:0]   k;
   logic [RES_W-1:0]   verdict;
   logic [LEN_W:0]     page_sum;
   logic [28:0]        prog_prod;
   logic [TICKS_W-1:0] prog_ticks;
   logic               do_op_action;
   logic               do_finish;
   logic [RES_W-1:0]   fin_status;
   logic               do_poll;
   poll_type           poll_tgt;
   logic [TICKS_W-1:0] poll_load;
   logic               is_start;

   // program wait time, ticks per byte times byte count
   assign prog_prod  = 29'(cfg.program_ticks_per_byte) * 29'(st.op_length);
   assign prog_ticks = prog_prod[TICKS_W-1:0];

   // page crossing sum for program starts
   assign page_sum = (LEN_W+1)'(req.address[PAGE_BITS-1:0]) + (LEN_W+1)'(req.length);

   assign is_start = (req.action == ACT_READ) || (req.action == ACT_PROGRAM) ||
                     (req.action == ACT_ERASE) || (req.action == ACT_SLEEP);

   always_comb begin
      nx           = st;
      burst        = '0;
      k            = '0;
      verdict      = ST_OK;
      do_op_action = 1'b0;
      do_finish    = 1'b0;
      fin_status   = ST_OK;
      do_poll      = 1'b0;
      poll_tgt     = PT_NONE;
      poll_load    = '0;

      // start requests
      if (is_start) begin
         if (req.action == ACT_SLEEP && st.asleep) begin
            burst.item[k] = mk_rsp(DIR_ACCEPTED, '0, '0, 1'b0, '0, '0, ST_OK);
            k = k + 2'd1;
         end else begin
            if (req.action == ACT_READ || req.action == ACT_PROGRAM) begin
               if (req.address >= ADDR_W'(MAX_ADDRESS))
                  verdict = ST_BAD_RANGE;
               else if (req.action == ACT_PROGRAM && page_sum > (LEN_W+1)'(PAGE_BYTES))
                  verdict = ST_BAD_PARAM;
            end else if (req.action == ACT_ERASE) begin
               if (req.length != SZ_4K && req.length != SZ_32K &&
                   req.length != SZ_64K && req.length != SZ_1M)
                  verdict = ST_BAD_COUNT;
               else if ((req.address & ADDR_W'(req.length - LEN_W'(1))) != '0)
                  verdict = ST_BAD_PARAM;
            end
            if (verdict == ST_OK && st.op != OP_NONE)
               verdict = ST_BUSY;
            burst.item[k] = mk_rsp(DIR_ACCEPTED, '0, '0, 1'b0, '0, '0, verdict);
            k = k + 2'd1;
            if (verdict == ST_OK) begin
               unique case (req.action)
                  ACT_READ:    nx.op = OP_READ;
                  ACT_PROGRAM: nx.op = OP_PROG;
                  ACT_ERASE:   nx.op = OP_ERASE;
                  default:     nx.op = OP_SLEEP;
               endcase
               nx.op_address  = (req.action == ACT_SLEEP) ? '0 : req.address;
               nx.op_length   = (req.action == ACT_SLEEP) ? '0 : req.length;
               nx.poll_target = PT_NONE;
               if (st.asleep) begin
                  // wake the part first with a select pulse
                  nx.asleep = 1'b0;
                  nx.phase  = PH_WAKE;
                  burst.item[k] = mk_rsp(DIR_RELEASE, '0, '0, 1'b0, '0, '0, ST_OK);
                  k = k + 2'd1;
                  burst.item[k] = mk_rsp(DIR_TIMER, '0, '0, 1'b0, '0,
                                         TICKS_W'(cfg.wakeup_ticks), ST_OK);
                  k = k + 2'd1;
               end else begin
                  do_op_action = 1'b1;
               end
            end
         end
      end else if (req.action == ACT_DONE) begin
         // transfer finished
         if (st.phase == PH_WREN || st.phase == PH_CMD || st.phase == PH_DATA ||
             st.phase == PH_PXFER) begin
            if (st.phase == PH_CMD && req.transfer_ok && st.op == OP_READ) begin
               nx.phase = PH_DATA;
               burst.item[k] = mk_rsp(DIR_RECEIVE, '0, '0, 1'b0, st.op_length, '0, ST_OK);
               k = k + 2'd1;
            end else if (st.phase == PH_CMD && req.transfer_ok && st.op == OP_PROG) begin
               nx.phase         = PH_DATA;
               nx.poll_interval = prog_ticks;
               burst.item[k] = mk_rsp(DIR_SEND, '0, '0, 1'b0, st.op_length, '0, ST_OK);
               k = k + 2'd1;
            end else begin
               burst.item[k] = mk_rsp(DIR_RELEASE, '0, '0, 1'b0, '0, '0, ST_OK);
               k = k + 2'd1;
               if (!req.transfer_ok) begin
                  do_finish  = 1'b1;
                  fin_status = ST_TX_ERROR;
               end else if (st.phase == PH_WREN) begin
                  do_poll    = 1'b1;
                  poll_tgt   = PT_WEL;
                  poll_load  = TICKS_W'(cfg.wel_poll_ticks);
               end else if (st.phase == PH_CMD || st.phase == PH_DATA) begin
                  if (st.op == OP_READ) begin
                     do_finish = 1'b1;
                  end else if (st.op == OP_PROG || st.op == OP_ERASE) begin
                     do_poll    = 1'b1;
                     poll_tgt   = PT_WIP;
                     poll_load  = st.poll_interval;
                  end else if (st.op == OP_SLEEP) begin
                     nx.phase = PH_SETTLE;
                     burst.item[k] = mk_rsp(DIR_TIMER, '0, '0, 1'b0, '0,
                                            TICKS_W'(cfg.sleep_settle_ticks), ST_OK);
                     k = k + 2'd1;
                  end else begin
                     do_finish  = 1'b1;
                     fin_status = ST_BAD_STATE;
                  end
               end else if (st.poll_target == PT_WEL) begin
                  // status read while waiting for write enable
                  if (!req.status_byte[WEL_BIT]) begin
                     do_poll    = 1'b1;
                     poll_tgt   = PT_WEL;
                     poll_load  = st.poll_interval;
                  end else if (st.op == OP_PROG) begin
                     nx.phase         = PH_CMD;
                     nx.poll_interval = prog_ticks;
                     burst.item[k] = mk_rsp(DIR_SEND_CMD, OPC_PP, st.op_address, 1'b1,
                                            '0, '0, ST_OK);
                     k = k + 2'd1;
                  end else if (st.op == OP_ERASE) begin
                     nx.phase = PH_CMD;
                     priority if (st.op_length == SZ_4K) begin
                        nx.poll_interval = cfg.erase_4k_ticks;
                        burst.item[k] = mk_rsp(DIR_SEND_CMD, OPC_SE4K, st.op_address, 1'b1,
                                               '0, '0, ST_OK);
                     end else if (st.op_length == SZ_32K) begin
                        nx.poll_interval = cfg.erase_32k_ticks;
                        burst.item[k] = mk_rsp(DIR_SEND_CMD, OPC_BE32K, st.op_address, 1'b1,
                                               '0, '0, ST_OK);
                     end else if (st.op_length == SZ_64K) begin
                        nx.poll_interval = cfg.erase_64k_ticks;
                        burst.item[k] = mk_rsp(DIR_SEND_CMD, OPC_BE64K, st.op_address, 1'b1,
                                               '0, '0, ST_OK);
                     end else begin
                        nx.poll_interval = cfg.chip_erase_ticks;
                        burst.item[k] = mk_rsp(DIR_SEND_CMD, OPC_CE, '0, 1'b0,
                                               '0, '0, ST_OK);
                     end
                     k = k + 2'd1;
                  end else begin
                     do_finish  = 1'b1;
                     fin_status = ST_BAD_STATE;
                  end
               end else if (st.poll_target == PT_WIP) begin
                  // status read while waiting for the write to end
                  if (req.status_byte[WIP_BIT]) begin
                     do_poll    = 1'b1;
                     poll_tgt   = PT_WIP;
                     poll_load  = st.poll_interval;
                  end else begin
                     do_finish  = 1'b1;
                     fin_status = (st.op == OP_PROG || st.op == OP_ERASE) ?
                                  ST_OK : ST_BAD_STATE;
                  end
               end else begin
                  do_finish  = 1'b1;
                  fin_status = ST_BAD_STATE;
               end
            end
         end
      end else if (req.action == ACT_TIMER) begin
         // timer expired
         if (st.phase == PH_WAKE) begin
            do_op_action = 1'b1;
         end else if (st.phase == PH_PWAIT) begin
            nx.phase = PH_PXFER;
            burst.item[k] = mk_rsp(DIR_RDSR, OPC_RDSR, '0, 1'b0, '0, '0, ST_OK);
            k = k + 2'd1;
         end else if (st.phase == PH_SETTLE) begin
            nx.asleep = 1'b1;
            do_finish = 1'b1;
         end
      end

      // first command of the operation
      if (do_op_action) begin
         if (nx.op == OP_READ) begin
            nx.phase = PH_CMD;
            burst.item[k] = mk_rsp(DIR_SEND_CMD, OPC_READ, nx.op_address, 1'b1,
                                   '0, '0, ST_OK);
            k = k + 2'd1;
         end else if (nx.op == OP_SLEEP) begin
            nx.phase = PH_CMD;
            burst.item[k] = mk_rsp(DIR_SEND_CMD, OPC_DP, '0, 1'b0, '0, '0, ST_OK);
            k = k + 2'd1;
         end else if (nx.op == OP_PROG || nx.op == OP_ERASE) begin
            nx.phase = PH_WREN;
            burst.item[k] = mk_rsp(DIR_SEND_CMD, OPC_WREN, '0, 1'b0, '0, '0, ST_OK);
            k = k + 2'd1;
         end else begin
            do_finish  = 1'b1;
            fin_status = ST_BAD_STATE;
         end
      end

      // arm the poll timer
      if (do_poll) begin
         nx.poll_target   = poll_tgt;
         nx.poll_interval = poll_load;
         nx.phase         = PH_PWAIT;
         burst.item[k] = mk_rsp(DIR_TIMER, '0, '0, 1'b0, '0, poll_load, ST_OK);
         k = k + 2'd1;
      end

      // end of operation
      if (do_finish) begin
         nx.op          = OP_NONE;
         nx.phase       = PH_IDLE;
         nx.poll_target = PT_NONE;
         burst.item[k] = mk_rsp(DIR_COMPLETE, '0, '0, 1'b0, '0, '0, fin_status);
         k = k + 2'd1;
      end

      // mark the final result of the item
      if (k != '0)
         burst.item[k - 2'd1].last = 1'b1;
      burst.count = k;
   end

endmodule

>>> rtl/core/spi_nor_flash_op_sequencer.sv
// top level of the spi nor flash operation sequencer
//
//   port group | dir | handshake             | content
//   req_*      | in  | req_valid / req_ready | event: start, transfer done, timer expired
//   rsp_*      | out | rsp_valid / rsp_ready | directive for spi and timer hardware
//   csr_*      | in  | csr_we                | timing registers, no read-back
//
// an item is decoded in the cycle it is accepted; its 0 to 3 results land in
// the output burst register and leave one per cycle while rsp_ready is high.
// a second burst waits in a holding slot, and req_ready drops only while that
// slot is full. reset clears the operation state, both burst slots and the
// timing registers to their defaults.
`timescale 1ns / 1ps
module spi_nor_flash_op_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  snfos_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output snfos_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic [snfos_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [snfos_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import snfos_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   seq_state_type    state_ff, state_in;
   seq_state_type    step_nx;
   burst_type        step_burst;
   burst_type        out_ff, out_in;
   burst_type        hold_ff, hold_in;
   logic             out_valid_ff, out_valid_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             new_burst;
   logic             out_done;
   logic             out_free;

   // item decode
   snfos_step u_step (
      .st    (state_ff),
      .cfg   (cfg_ff),
      .req   (req_data),
      .nx    (step_nx),
      .burst (step_burst)
   );

   assign req_ready = !hold_valid_ff;
   assign accept    = req_valid && req_ready;
   assign new_burst = accept && (step_burst.count != '0);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff.item[idx_ff];
   assign out_done  = out_valid_ff && rsp_ready && (idx_ff == out_ff.count - 2'd1);
   assign out_free  = !out_valid_ff || out_done;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WEL_POLL:   cfg_in.wel_poll_ticks         = csr_wdata[15:0];
            CSR_PROG_TPB:   cfg_in.program_ticks_per_byte = csr_wdata[7:0];
            CSR_ERASE_4K:   cfg_in.erase_4k_ticks         = csr_wdata;
            CSR_ERASE_32K:  cfg_in.erase_32k_ticks        = csr_wdata;
            CSR_ERASE_64K:  cfg_in.erase_64k_ticks        = csr_wdata;
            CSR_CHIP_ERASE: cfg_in.chip_erase_ticks       = csr_wdata;
            CSR_WAKEUP:     cfg_in.wakeup_ticks           = csr_wdata[7:0];
            CSR_SLEEP:      cfg_in.sleep_settle_ticks     = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer state advances on each accepted item
   assign state_in = accept ? step_nx : state_ff;

   // output burst and holding slot
   always_comb begin
      out_in        = out_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff;
      hold_valid_in = hold_valid_ff;
      idx_in        = idx_ff;
      if (out_free) begin
         idx_in = '0;
         if (hold_valid_ff) begin
            out_in        = hold_ff;
            out_valid_in  = 1'b1;
            hold_valid_in = 1'b0;
         end else begin
            out_in       = step_burst;
            out_valid_in = new_burst;
         end
      end else begin
         if (rsp_ready)
            idx_in = idx_ff + 2'd1;
         if (new_burst) begin
            hold_in       = step_burst;
            hold_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wel_poll_ticks         <= 16'd10;
         cfg_ff.program_ticks_per_byte <= 8'd3;
         cfg_ff.erase_4k_ticks         <= 24'd1966;
         cfg_ff.erase_32k_ticks        <= 24'd13107;
         cfg_ff.erase_64k_ticks        <= 24'd26214;
         cfg_ff.chip_erase_ticks       <= 24'd491520;
         cfg_ff.wakeup_ticks           <= 8'd2;
         cfg_ff.sleep_settle_ticks     <= 8'd3;
         state_ff.op                   <= OP_NONE;
         state_ff.phase                <= PH_IDLE;
         state_ff.poll_target          <= PT_NONE;
         state_ff.asleep               <= 1'b0;
         state_ff.op_address           <= '0;
         state_ff.op_length            <= '0;
         state_ff.poll_interval        <= '0;
         out_valid_ff                  <= 1'b0;
         hold_valid_ff                 <= 1'b0;
         idx_ff                        <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
      end
   end

   // burst payload, no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

endmodule

>>> rtl/core/snfos_checker.sv
// port-level checks for the spi nor flash operation sequencer
`timescale 1ns / 1ps
module snfos_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input snfos_pkg::rsp_type rsp_data
);
   import snfos_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // completion always ends the item
   a_complete_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.directive == DIR_COMPLETE |-> rsp_data.last)
      else $error("complete not marked last");

   // a rejected start gives nothing more
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.directive == DIR_ACCEPTED && rsp_data.status != ST_OK
      |-> rsp_data.last)
      else $error("rejected start not last");

   // input stalls only behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind spi_nor_flash_op_sequencer snfos_checker u_snfos_checker (.*);

>>> bench/testbench.sv
// self-checking testbench for the spi nor flash operation sequencer
`timescale 1ns / 1ps

import snfos_pkg::*;

// tracks the flash sequencing state and checks every directive the block emits
class directive_checker;
   cfg_type          cfg;
   op_type           op;
   phase_type        ph;
   poll_type         poll;
   logic             asleep;
   logic [ADDR_W-1:0]  op_addr;
   logic [LEN_W-1:0]   op_len;
   logic [TICKS_W-1:0] interval;
   rsp_type          directive_q[$];
   rsp_type          step_q[$];
   int               last_count;
   int               mismatches;

   function new();
      cfg.wel_poll_ticks         = 16'd10;
      cfg.program_ticks_per_byte = 8'd3;
      cfg.erase_4k_ticks         = 24'd1966;
      cfg.erase_32k_ticks        = 24'd13107;
      cfg.erase_64k_ticks        = 24'd26214;
      cfg.chip_erase_ticks       = 24'd491520;
      cfg.wakeup_ticks           = 8'd2;
      cfg.sleep_settle_ticks     = 8'd3;
      op         = OP_NONE;
      ph         = PH_IDLE;
      poll       = PT_NONE;
      asleep     = 1'b0;
      op_addr    = '0;
      op_len     = '0;
      interval   = '0;
      last_count = 0;
      mismatches = 0;
   endfunction

   function void put(logic [DIR_W-1:0] dir, logic [OPC_W-1:0] opc, logic [ADDR_W-1:0] addr,
                     logic wa, logic [LEN_W-1:0] cnt, logic [TICKS_W-1:0] ticks,
                     logic [RES_W-1:0] st);
      rsp_type r;
      r.directive    = dir;
      r.opcode       = opc;
      r.cmd_address  = addr;
      r.with_address = wa;
      r.byte_count   = cnt;
      r.timer_ticks  = ticks;
      r.status       = st;
      r.last         = 1'b0;
      step_q.push_back(r);
   endfunction

   function logic [TICKS_W-1:0] prog_ticks();
      logic [28:0] prod;
      prod = cfg.program_ticks_per_byte * op_len;
      return prod[TICKS_W-1:0];
   endfunction

   function void complete(logic [RES_W-1:0] st);
      op   = OP_NONE;
      ph   = PH_IDLE;
      poll = PT_NONE;
      put(DIR_COMPLETE, '0, '0, 1'b0, '0, '0, st);
   endfunction

   function void arm_poll(poll_type target, logic [TICKS_W-1:0] ticks);
      poll     = target;
      interval = ticks;
      ph       = PH_PWAIT;
      put(DIR_TIMER, '0, '0, 1'b0, '0, interval, ST_OK);
   endfunction

   // first command of an operation, right after the start or the wakeup wait
   function void issue_op();
      if (op == OP_READ) begin
         ph = PH_CMD;
         put(DIR_SEND_CMD, OPC_READ, op_addr, 1'b1, '0, '0, ST_OK);
      end else if (op == OP_SLEEP) begin
         ph = PH_CMD;
         put(DIR_SEND_CMD, OPC_DP, '0, 1'b0, '0, '0, ST_OK);
      end else if (op == OP_PROG || op == OP_ERASE) begin
         ph = PH_WREN;
         put(DIR_SEND_CMD, OPC_WREN, '0, 1'b0, '0, '0, ST_OK);
      end else begin
         complete(ST_BAD_STATE);
      end
   endfunction

   // write enable latched: send the program or erase command
   function void wel_ready();
      ph = PH_CMD;
      if (op == OP_PROG) begin
         interval = prog_ticks();
         put(DIR_SEND_CMD, OPC_PP, op_addr, 1'b1, '0, '0, ST_OK);
      end else if (op == OP_ERASE) begin
         if (op_len == SZ_4K) begin
            interval = cfg.erase_4k_ticks;
            put(DIR_SEND_CMD, OPC_SE4K, op_addr, 1'b1, '0, '0, ST_OK);
         end else if (op_len == SZ_32K) begin
            interval = cfg.erase_32k_ticks;
            put(DIR_SEND_CMD, OPC_BE32K, op_addr, 1'b1, '0, '0, ST_OK);
         end else if (op_len == SZ_64K) begin
            interval = cfg.erase_64k_ticks;
            put(DIR_SEND_CMD, OPC_BE64K, op_addr, 1'b1, '0, '0, ST_OK);
         end else begin
            interval = cfg.chip_erase_ticks;
            put(DIR_SEND_CMD, OPC_CE, '0, 1'b0, '0, '0, ST_OK);
         end
      end else begin
         complete(ST_BAD_STATE);
      end
   endfunction

   function void transfer_done(logic ok, logic [STATUS_W-1:0] stat);
      // command sent: read and program move their data next
      if (ph == PH_CMD && ok && op == OP_READ) begin
         ph = PH_DATA;
         put(DIR_RECEIVE, '0, '0, 1'b0, op_len, '0, ST_OK);
         return;
      end
      if (ph == PH_CMD && ok && op == OP_PROG) begin
         ph       = PH_DATA;
         interval = prog_ticks();
         put(DIR_SEND, '0, '0, 1'b0, op_len, '0, ST_OK);
         return;
      end
      put(DIR_RELEASE, '0, '0, 1'b0, '0, '0, ST_OK);
      if (!ok) begin
         complete(ST_TX_ERROR);
      end else if (ph == PH_WREN) begin
         arm_poll(PT_WEL, TICKS_W'(cfg.wel_poll_ticks));
      end else if (ph == PH_CMD || ph == PH_DATA) begin
         if (op == OP_READ) begin
            complete(ST_OK);
         end else if (op == OP_PROG || op == OP_ERASE) begin
            arm_poll(PT_WIP, interval);
         end else if (op == OP_SLEEP) begin
            ph = PH_SETTLE;
            put(DIR_TIMER, '0, '0, 1'b0, '0, TICKS_W'(cfg.sleep_settle_ticks), ST_OK);
         end else begin
            complete(ST_BAD_STATE);
         end
      // status register read finished
      end else if (poll == PT_WEL) begin
         if (!stat[WEL_BIT]) arm_poll(PT_WEL, interval);
         else wel_ready();
      end else if (poll == PT_WIP) begin
         if (stat[WIP_BIT]) arm_poll(PT_WIP, interval);
         else if (op == OP_PROG || op == OP_ERASE) complete(ST_OK);
         else complete(ST_BAD_STATE);
      end else begin
         complete(ST_BAD_STATE);
      end
   endfunction

   // accepted input item: work out the directives it causes
   function void take_event(req_type it);
      logic [RES_W-1:0] verdict;
      logic [31:0]      page_end;
      rsp_type          r;
      step_q.delete();
      if (it.action <= ACT_SLEEP) begin
         if (it.action == ACT_SLEEP && asleep) begin
            put(DIR_ACCEPTED, '0, '0, 1'b0, '0, '0, ST_OK);
         end else begin
            verdict  = ST_OK;
            page_end = (32'(it.address) % PAGE_BYTES) + 32'(it.length);
            if (it.action == ACT_READ || it.action == ACT_PROGRAM) begin
               if (it.address >= MAX_ADDRESS) verdict = ST_BAD_RANGE;
               else if (it.action == ACT_PROGRAM && page_end > PAGE_BYTES)
                  verdict = ST_BAD_PARAM;
            end else if (it.action == ACT_ERASE) begin
               if (it.length != SZ_4K && it.length != SZ_32K && it.length != SZ_64K &&
                   it.length != SZ_1M)
                  verdict = ST_BAD_COUNT;
               else if ((it.address & ADDR_W'(it.length - 1)) != 0)
                  verdict = ST_BAD_PARAM;
            end
            if (verdict == ST_OK && op != OP_NONE) verdict = ST_BUSY;
            put(DIR_ACCEPTED, '0, '0, 1'b0, '0, '0, verdict);
            if (verdict == ST_OK) begin
               case (it.action)
                  ACT_READ:    op = OP_READ;
                  ACT_PROGRAM: op = OP_PROG;
                  ACT_ERASE:   op = OP_ERASE;
                  default:     op = OP_SLEEP;
               endcase
               op_addr = (it.action == ACT_SLEEP) ? '0 : it.address;
               op_len  = (it.action == ACT_SLEEP) ? '0 : it.length;
               poll    = PT_NONE;
               // asleep: pulse select and wait before the real command
               if (asleep) begin
                  asleep = 1'b0;
                  ph     = PH_WAKE;
                  put(DIR_RELEASE, '0, '0, 1'b0, '0, '0, ST_OK);
                  put(DIR_TIMER, '0, '0, 1'b0, '0, TICKS_W'(cfg.wakeup_ticks), ST_OK);
               end else begin
                  issue_op();
               end
            end
         end
      end else if (it.action == ACT_DONE) begin
         if (ph == PH_WREN || ph == PH_CMD || ph == PH_DATA || ph == PH_PXFER)
            transfer_done(it.transfer_ok, it.status_byte);
      end else if (it.action == ACT_TIMER) begin
         if (ph == PH_WAKE) begin
            issue_op();
         end else if (ph == PH_PWAIT) begin
            ph = PH_PXFER;
            put(DIR_RDSR, OPC_RDSR, '0, 1'b0, '0, '0, ST_OK);
         end else if (ph == PH_SETTLE) begin
            asleep = 1'b1;
            complete(ST_OK);
         end
      end
      if (step_q.size() > 0) begin
         r      = step_q.pop_back();
         r.last = 1'b1;
         step_q.push_back(r);
      end
      last_count = step_q.size();
      foreach (step_q[i]) directive_q.push_back(step_q[i]);
   endfunction

   function string show(rsp_type r);
      return $sformatf("dir=%0d opc=%02h addr=%06h wa=%0b cnt=%0d ticks=%0d st=%0d last=%0b",
                       r.directive, r.opcode, r.cmd_address, r.with_address, r.byte_count,
                       r.timer_ticks, r.status, r.last);
   endfunction

   // accepted directive: compare with the oldest one waiting
   function void check_directive(rsp_type got);
      rsp_type want;
      if (directive_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected directive: %s", show(got));
         return;
      end
      want = directive_q.pop_front();
      if (got.directive !== want.directive || got.opcode !== want.opcode ||
          got.cmd_address !== want.cmd_address || got.with_address !== want.with_address ||
          got.byte_count !== want.byte_count || got.timer_ticks !== want.timer_ticks ||
          got.status !== want.status || got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directive mismatch: expected %s, got %s", show(want), show(got));
      end
   endfunction
endclass

module testbench;

   localparam int TIMEOUT_NS   = 10_000_000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 75;

   // action codes the block must ignore
   localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd7;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SPARSE, RX_HOLD} rx_mode_e;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   directive_checker sb;

   spi_nor_flash_op_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // both handshakes sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.take_event(req_data);
      if (!reset && rsp_valid && rsp_ready) sb.check_directive(rsp_data);
   end

   function automatic req_type ev(logic [ACTION_W-1:0] action, logic [ADDR_W-1:0] address,
                                  logic [LEN_W-1:0] length, logic ok,
                                  logic [STATUS_W-1:0] stat);
      req_type it;
      it.action      = action;
      it.address     = address;
      it.length      = length;
      it.transfer_ok = ok;
      it.status_byte = stat;
      return it;
   endfunction

   // next item: mostly what the flash sequence waits for, some noise
   function automatic req_type make_event();
      req_type        it;
      logic [LEN_W-1:0] sz;
      int unsigned    pick;
      int unsigned    room;
      it = ev(ACT_TIMER, ADDR_W'($urandom), LEN_W'($urandom), 1'($urandom), 8'($urandom));
      if ($urandom_range(0, 99) < 12) begin
         it.action = ACTION_W'($urandom);
         return it;
      end
      if (sb.ph == PH_IDLE) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            it.action  = ACT_READ;
            it.address = ADDR_W'($urandom_range(0, MAX_ADDRESS - 1));
            it.length  = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, SZ_1M))
                                                     : LEN_W'($urandom_range(0, 300));
         end else if (pick < 60) begin
            it.action  = ACT_PROGRAM;
            it.address = ADDR_W'($urandom_range(0, MAX_ADDRESS - 1));
            room       = PAGE_BYTES - (32'(it.address) % PAGE_BYTES);
            it.length  = LEN_W'($urandom_range(0, room));
            if ($urandom_range(0, 9) == 0) it.length = LEN_W'($urandom_range(0, PAGE_BYTES));
         end else if (pick < 85) begin
            it.action = ACT_ERASE;
            case ($urandom_range(0, 9))
               0, 1, 2, 3: sz = SZ_4K;
               4, 5, 6:    sz = SZ_32K;
               7, 8:       sz = SZ_64K;
               default:    sz = SZ_1M;
            endcase
            it.length = sz;
            if ($urandom_range(0, 9) != 0) it.address = it.address & ~ADDR_W'(sz - 1);
         end else begin
            it.action = ACT_SLEEP;
         end
      end else if (sb.ph == PH_WAKE || sb.ph == PH_PWAIT || sb.ph == PH_SETTLE) begin
         it.action = ACT_TIMER;
      end else begin
         it.action               = ACT_DONE;
         it.transfer_ok          = ($urandom_range(0, 99) >= 4);
         it.status_byte[WEL_BIT] = ($urandom_range(0, 99) < 65);
         it.status_byte[WIP_BIT] = ($urandom_range(0, 99) >= 65);
      end
      return it;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input req_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      put_reg(CSR_WEL_POLL, CSR_DATA_W'(c.wel_poll_ticks));
      put_reg(CSR_PROG_TPB, CSR_DATA_W'(c.program_ticks_per_byte));
      put_reg(CSR_ERASE_4K, c.erase_4k_ticks);
      put_reg(CSR_ERASE_32K, c.erase_32k_ticks);
      put_reg(CSR_ERASE_64K, c.erase_64k_ticks);
      put_reg(CSR_CHIP_ERASE, c.chip_erase_ticks);
      put_reg(CSR_WAKEUP, CSR_DATA_W'(c.wakeup_ticks));
      put_reg(CSR_SLEEP, CSR_DATA_W'(c.sleep_settle_ticks));
      csr_we <= 1'b0;
      sb.cfg = c;
   endtask

   // wait for every expected directive, then for anything still in flight
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.directive_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_directed();
      // stray events and unused action codes
      send_item(ev(ACT_TIMER, 24'hFFFFFF, 21'h1FFFFF, 1'b1, 8'hFF));
      send_item(ev(ACT_RSVD_A, 24'h000000, 21'h000000, 1'b0, 8'h00));
      send_item(ev(ACT_RSVD_B, 24'hFFFFFF, 21'h1FFFFF, 1'b1, 8'hFF));
      // rejected starts: range edge, page crossing, odd erase size, misaligned erase
      send_item(ev(ACT_READ, ADDR_W'(MAX_ADDRESS), 21'd16, 1'b1, 8'h00));
      send_item(ev(ACT_PROGRAM, 24'h0000F0, 21'd17, 1'b1, 8'h00));
      send_item(ev(ACT_ERASE, 24'h000000, 21'd4095, 1'b1, 8'h00));
      send_item(ev(ACT_ERASE, 24'h000800, SZ_4K, 1'b1, 8'h00));
      // zero-length program through both polls, with a start while busy
      send_item(ev(ACT_PROGRAM, 24'h001000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_READ, 24'h000000, 21'd4, 1'b1, 8'h00));
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_TIMER, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_TIMER, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b1, 8'hFF));
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_TIMER, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b1, 8'h02));
      // deep sleep, sleep again while asleep, then wake on a read
      send_item(ev(ACT_SLEEP, 24'hABCDEF, 21'd99, 1'b1, 8'h00));
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_TIMER, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_SLEEP, 24'h000000, 21'd0, 1'b1, 8'h00));
      send_item(ev(ACT_READ, 24'h0FFFFE, SZ_1M, 1'b1, 8'h00));
      send_item(ev(ACT_TIMER, 24'h000000, 21'd0, 1'b1, 8'h00));
      // failed transfer ends the read
      send_item(ev(ACT_DONE, 24'h000000, 21'd0, 1'b0, 8'h00));
   endtask

   // bursts of items with random gaps; ignored items do not count
   task automatic run_random(input int quota);
      int counted;
      int burst;
      int gap;
      counted = 0;
      while (counted < quota) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            send_item(make_event());
            if (sb.last_count > 0) counted++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.wel_poll_ticks         = 16'($urandom_range(1, 16'hFFFF));
      c.program_ticks_per_byte = 8'($urandom_range(1, 8'hFF));
      c.erase_4k_ticks         = 24'($urandom_range(1, 24'hFFFFFF));
      c.erase_32k_ticks        = 24'($urandom_range(1, 24'hFFFFFF));
      c.erase_64k_ticks        = 24'($urandom_range(1, 24'hFFFFFF));
      c.chip_erase_ticks       = 24'($urandom_range(1, 24'hFFFFFF));
      c.wakeup_ticks           = 8'($urandom_range(1, 8'hFF));
      c.sleep_settle_ticks     = 8'($urandom_range(1, 8'hFF));
      return c;
   endfunction

   // receiver: segments of different stall patterns, now and then a long hold-off
   initial begin
      int       seg;
      int       span;
      rx_mode_e mode;
      rsp_ready = 1'b0;
      seg       = 0;
      forever begin
         seg++;
         if (seg % 20 == 6) begin
            mode = RX_HOLD;
            span = $urandom_range(80, 160);
         end else begin
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(1, 40);
         end
         repeat (span) begin
            @(negedge clock);
            case (mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom);
               RX_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= 1'b0;
            endcase
         end
      end
   end

   initial begin
      cfg_type c;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sb        = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset values of the timing registers
      run_directed();

      // smallest settings
      settle();
      c.wel_poll_ticks         = 16'd1;
      c.program_ticks_per_byte = 8'd1;
      c.erase_4k_ticks         = 24'd1;
      c.erase_32k_ticks        = 24'd1;
      c.erase_64k_ticks        = 24'd1;
      c.chip_erase_ticks       = 24'd1;
      c.wakeup_ticks           = 8'd1;
      c.sleep_settle_ticks     = 8'd1;
      apply_config(c);
      run_random(PHASE_ITEMS);

      // largest settings
      settle();
      c.wel_poll_ticks         = 16'hFFFF;
      c.program_ticks_per_byte = 8'hFF;
      c.erase_4k_ticks         = 24'hFFFFFF;
      c.erase_32k_ticks        = 24'hFFFFFF;
      c.erase_64k_ticks        = 24'hFFFFFF;
      c.chip_erase_ticks       = 24'hFFFFFF;
      c.wakeup_ticks           = 8'hFF;
      c.sleep_settle_ticks     = 8'hFF;
      apply_config(c);
      run_random(PHASE_ITEMS);

      // random settings
      repeat (2) begin
         settle();
         apply_config(random_cfg());
         run_random(PHASE_ITEMS);
      end

      settle();
      if (sb.mismatches == 0 && sb.directive_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
